// File: design/jet_colormap_rgb_top_defines.svh
// ----------------------------------------------------------------------------
// Jet colormap assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef JET_COLORMAP_RGB_TOP_DEFINES_SVH
`define JET_COLORMAP_RGB_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is asserted.
`define JCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jcm assertion failed");

// Check a property on every rising edge, reset included.
`define JCM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("jcm assertion failed");

`else

`define JCM_ASSERT(lbl, clk, rst_n, prop)
`define JCM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: design/jcm_pkg.sv
// ----------------------------------------------------------------------------
// Jet colormap package
// Shared widths, breakpoint sets, register codes, reciprocals and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package jcm_pkg;

  localparam int unsigned PixW  = 16;
  localparam int unsigned ChW   = 8;
  localparam int unsigned QuoW  = 8;
  localparam int unsigned ModeW = 2;
  // Numerator, reciprocal width and shift of the constant dividers:
  // quotient = (num * ceil(2^RecipSh / span)) >> RecipSh, exact for every
  // numerator that a segment can produce.
  localparam int unsigned NumW    = 22;
  localparam int unsigned RecipW  = 30;
  localparam int unsigned RecipSh = 34;
  // Blue ramp numerator before its 2^16 scale is dropped.
  localparam int unsigned BlueW   = 37;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int unsigned Latency = 2;

  // APB register map
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic REG_DEPTH_MODE = 1'b0;

  // depth_mode codes
  localparam logic [ModeW-1:0] MODE_8B  = 2'd0;
  localparam logic [ModeW-1:0] MODE_12B = 2'd1;
  localparam logic [ModeW-1:0] MODE_16B = 2'd2;
  localparam logic [ModeW-1:0] DEPTH_MODE_RST = MODE_12B;

  // (255.0 - 255*0.51563) in Q7.16: slope of the blue ramp.
  localparam logic [22:0] BLUE_SLOPE = 23'd8094637;

  // 255*0.51563 in Q8.16 scaled by x0 of each set.
  localparam logic [BlueW-1:0] BLUE_OFS_8B  = BlueW'(64'd8617043 * 64'd31);
  localparam logic [BlueW-1:0] BLUE_OFS_12B = BlueW'(64'd8617043 * 64'd498);
  localparam logic [BlueW-1:0] BLUE_OFS_16B = BlueW'(64'd8617043 * 64'd7967);

  // ceil(2^34 / span) for every span that a segment divides by
  localparam logic [RecipW-1:0] RCP_31    = 30'd554189329;
  localparam logic [RecipW-1:0] RCP_64    = 30'd268435456;
  localparam logic [RecipW-1:0] RCP_498   = 30'd34497730;
  localparam logic [RecipW-1:0] RCP_1027  = 30'd16728208;
  localparam logic [RecipW-1:0] RCP_1028  = 30'd16711936;
  localparam logic [RecipW-1:0] RCP_7967  = 30'd2156379;
  localparam logic [RecipW-1:0] RCP_16448 = 30'd1044496;

  typedef enum logic [2:0] {
    SEG_BLUE,
    SEG_GREEN_UP,
    SEG_MID,
    SEG_GREEN_DN,
    SEG_RED,
    SEG_WHITE
  } seg_e;

  typedef struct packed {
    seg_e seg;
  } item_meta_t;

  typedef struct packed {
    logic [PixW-1:0] x0;
    logic [PixW-1:0] x1;
    logic [PixW-1:0] x2;
    logic [PixW-1:0] x3;
    logic [PixW-1:0] x4;
  } bp_set_t;

  function automatic bp_set_t bp_set(input logic [ModeW-1:0] mode);
    bp_set_t s;
    case (mode)
      MODE_8B:  s = '{16'd31,   16'd95,    16'd159,   16'd223,   16'd255};
      MODE_12B: s = '{16'd498,  16'd1526,  16'd2553,  16'd3581,  16'd4095};
      default:  s = '{16'd7967, 16'd24415, 16'd40863, 16'd57311, 16'd65535};
    endcase
    return s;
  endfunction

  function automatic logic [BlueW-1:0] blue_ofs(input logic [ModeW-1:0] mode);
    logic [BlueW-1:0] o;
    case (mode)
      MODE_8B:  o = BLUE_OFS_8B;
      MODE_12B: o = BLUE_OFS_12B;
      default:  o = BLUE_OFS_16B;
    endcase
    return o;
  endfunction

  // Blue divides by x0, the red fall by twice x4-x3, the rest by their span.
  function automatic logic [RecipW-1:0] recip(input logic [ModeW-1:0] mode,
                                              input seg_e seg);
    logic [RecipW-1:0] r;
    case (mode)
      MODE_8B:  r = (seg == SEG_BLUE) ? RCP_31 : RCP_64;
      MODE_12B: r = (seg == SEG_BLUE) ? RCP_498 :
                    (seg == SEG_MID)  ? RCP_1027 : RCP_1028;
      default:  r = (seg == SEG_BLUE) ? RCP_7967 : RCP_16448;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/jcm_divider.sv
// ----------------------------------------------------------------------------
// Jet colormap divider
// Division by a constant span through a reciprocal multiply, 8-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module jcm_divider (
  input  wire logic [jcm_pkg::NumW-1:0]    num_i,
  input  wire logic [jcm_pkg::RecipW-1:0]  recip_i,
  output logic      [jcm_pkg::QuoW-1:0]    quo_o
);
  import jcm_pkg::*;

  logic [NumW+RecipW-1:0] prod;

  // quotient sits just above the reciprocal's binary point
  assign prod  = num_i * recip_i;
  assign quo_o = prod[RecipSh +: QuoW];

endmodule

`default_nettype wire

// File: design/jet_colormap_rgb_top.sv
// ----------------------------------------------------------------------------
// Jet colormap RGB top
// Maps a grey pixel to a jet false-color RGB triple, 8/12/16-bit input sets.
// ----------------------------------------------------------------------------
// Timing: an accepted item passes the input register, then the result
//   register, before done_o rises; one result per item.
// Throughput: one item per clock; busy_o stays low, every span is a constant
//   divided out by a reciprocal multiply, and the receiver cannot stall.
// Reset: asynchronous, active low; clears all valid bits and sets depth_mode
//   to twelve-bit. No clearing pass; items are accepted right after reset.
`default_nettype none
`include "jet_colormap_rgb_top_defines.svh"

module jet_colormap_rgb_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [jcm_pkg::AddrW-1:0]   paddr,
  input  wire logic [jcm_pkg::DataW-1:0]   pwdata,
  output logic [jcm_pkg::DataW-1:0]        prdata,
  output logic                             pready,
  // item in
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [jcm_pkg::PixW-1:0]    pixel_value_i,
  // result out
  output logic                             done_o,
  output logic [jcm_pkg::ChW-1:0]          red_o,
  output logic [jcm_pkg::ChW-1:0]          green_o,
  output logic [jcm_pkg::ChW-1:0]          blue_o
);
  import jcm_pkg::*;

  // multiply a span by 255 with a shift and a subtract
  function automatic logic [NumW-1:0] mul255(input logic [PixW:0] n);
    return NumW'({n, 8'h00}) - NumW'(n);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [ModeW-1:0] depth_mode_q;
  logic             cfg_wr;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_sel == REG_DEPTH_MODE);
  assign prdata  = (reg_sel == REG_DEPTH_MODE) ? DataW'(depth_mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q <= DEPTH_MODE_RST;
    end else if (cfg_wr) begin
      depth_mode_q <= pwdata[ModeW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Segment decode: every channel that ramps is floor(num / span) with a
  // quotient below 256, and every span is a constant of the depth set, so
  // the decode picks a numerator and the reciprocal of its span.
  // Ramps: num = 255*n. Middle segment: blue gets its own numerator.
  // Blue ramp: b = floor(floor((A*x0 + v*K) / 2^16) / x0).
  // Red fall:  r = floor(255*((x4-v) + (x4-x3)) / (2*(x4-x3))).
  // --------------------------------------------------------------------------
  logic              accept;
  logic [ModeW-1:0]  mode_eff;
  bp_set_t           bp;
  logic [PixW-1:0]   v;
  logic [BlueW-1:0]  blue_num;
  logic [PixW-1:0]   d43;
  logic [NumW-1:0]   num_a_d;
  logic [NumW-1:0]   num_b_d;
  logic [RecipW-1:0] rcp_d;
  item_meta_t        meta_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    // unused mode code falls back to the sixteen-bit set
    mode_eff = ((depth_mode_q == MODE_8B) || (depth_mode_q == MODE_12B)) ?
               depth_mode_q : MODE_16B;
    bp       = bp_set(mode_eff);
    // clamp to the set's full scale
    v        = (pixel_value_i > bp.x4) ? bp.x4 : pixel_value_i;
    blue_num = blue_ofs(mode_eff) + BlueW'(v) * BlueW'(BLUE_SLOPE);
    d43      = bp.x4 - bp.x3;
    num_b_d  = '0;

    if (v < bp.x0) begin
      meta_d.seg = SEG_BLUE;
      num_a_d    = NumW'(blue_num[BlueW-1:16]);
    end else if (v <= bp.x1) begin
      meta_d.seg = SEG_GREEN_UP;
      num_a_d    = mul255({1'b0, v - bp.x0});
    end else if (v < bp.x2) begin
      meta_d.seg = SEG_MID;
      num_a_d    = mul255({1'b0, v - bp.x1});
      num_b_d    = mul255({1'b0, bp.x2 - v});
    end else if (v <= bp.x3) begin
      meta_d.seg = SEG_GREEN_DN;
      num_a_d    = mul255({1'b0, bp.x3 - v});
    end else if ((mode_eff == MODE_12B) && (v == bp.x4)) begin
      // twelve-bit full scale shows white
      meta_d.seg = SEG_WHITE;
      num_a_d    = '0;
    end else begin
      meta_d.seg = SEG_RED;
      num_a_d    = mul255({1'b0, bp.x4 - v} + {1'b0, d43});
    end

    rcp_d = recip(mode_eff, meta_d.seg);
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              s1_vld_q;
  logic [NumW-1:0]   s1_num_a_q;
  logic [NumW-1:0]   s1_num_b_q;
  logic [RecipW-1:0] s1_rcp_q;
  item_meta_t        s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_a_q <= num_a_d;
    s1_num_b_q <= num_b_d;
    s1_rcp_q   <= rcp_d;
    s1_meta_q  <= meta_d;
  end

  // --------------------------------------------------------------------------
  // Constant dividers: the main channel, and falling blue of the middle span
  // --------------------------------------------------------------------------
  logic [QuoW-1:0] quo_a;
  logic [QuoW-1:0] quo_b;

  jcm_divider u_div_a (
    .num_i   (s1_num_a_q),
    .recip_i (s1_rcp_q),
    .quo_o   (quo_a)
  );

  jcm_divider u_div_b (
    .num_i   (s1_num_b_q),
    .recip_i (s1_rcp_q),
    .quo_o   (quo_b)
  );

  // --------------------------------------------------------------------------
  // Channel assembly and result register
  // --------------------------------------------------------------------------
  logic [ChW-1:0] red_d;
  logic [ChW-1:0] green_d;
  logic [ChW-1:0] blue_d;
  logic [ChW-1:0] red_q;
  logic [ChW-1:0] green_q;
  logic [ChW-1:0] blue_q;
  logic           done_q;

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (s1_meta_q.seg)
      SEG_BLUE: begin
        blue_d = quo_a;
      end
      SEG_GREEN_UP: begin
        green_d = quo_a;
        blue_d  = '1;
      end
      SEG_MID: begin
        red_d   = quo_a;
        green_d = '1;
        blue_d  = quo_b;
      end
      SEG_GREEN_DN: begin
        red_d   = '1;
        green_d = quo_a;
      end
      SEG_WHITE: begin
        red_d   = '1;
        green_d = '1;
        blue_d  = '1;
      end
      SEG_RED: begin
        red_d = quo_a;
      end
      default: begin
        red_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `JCM_ASSERT(a_result_has_item, clk_i, rst_ni,
              done_o |-> $past(start_i, Latency))
  `JCM_ASSERT(a_item_gets_result, clk_i, rst_ni,
              accept |-> ##Latency done_o)
  `JCM_ASSERT(a_white_only_full, clk_i, rst_ni,
              (done_o && red_o == 8'hFF && blue_o == 8'hFF) |-> green_o == 8'hFF)
  `JCM_ASSERT_ALWAYS(a_no_result_in_reset, clk_i,
                     !rst_ni |-> !done_o)

endmodule

`default_nettype wire
